// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers, sampled on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/fqir_pkg.sv =====
// ----------------------------------------------------------------------------
// fqir_pkg
// Types, codes and ring helpers for the indexed-remove queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fqir_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = 5;
  localparam int POS_W      = 4;

  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_DEQ = 2'd1;
  localparam logic [1:0] CMD_REM = 2'd2;
  localparam logic [1:0] CMD_RD  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [31:0]      value;
    logic [POS_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [31:0]      value_out;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } rsp_t;

  // ring slot of the entry at an offset from the front
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] front,
                                                input logic [CNT_W-1:0]  offset);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W+1-ADDR_W){1'b0}}, front} + {1'b0, offset};
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fqir_ram.sv =====
// ----------------------------------------------------------------------------
// fqir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fqir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/fifo_queue_with_indexed_remove.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_indexed_remove
// Ring-buffer queue with enqueue, dequeue, remove-at and read-at commands.
// ----------------------------------------------------------------------------
//  channel   | signals                       | handshake
//  ----------+-------------------------------+---------------------------
//  command   | start, busy, req_i            | taken when start && !busy
//  result    | valid_o, rsp_o                | one-cycle strobe, no stall
//
//  enqueue: result in the cycle after the command, next command at once
//  dequeue and read-at: result from S_READ, after the registered ram read
//  remove-at: result from S_RMHD, then S_SHIFT moves count - 1 - position entries, one per cycle
//  rejected dequeue, read-at and remove-at: result in the cycle after, like enqueue
//  reset leaves an empty queue at slot zero; the ram needs no clearing
//  busy holds the command port off while the ram is in use
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_indexed_remove (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire fqir_pkg::req_t req_i,
  output logic               valid_o,
  output fqir_pkg::rsp_t     rsp_o
);
  import fqir_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_RMHD  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [1:0]        cmd_q, cmd_d;
  logic              valid_q, valid_d;
  rsp_t              rsp_q, rsp_d;

  logic                  we;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic [CNT_W-1:0]      pos_ext, idx_ext;

  assign pos_ext = CNT_W'(req_i.position);
  assign idx_ext = CNT_W'(idx_q);

  fqir_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    front_d = front_q;
    count_d = count_q;
    idx_d   = idx_q;
    cmd_d   = cmd_q;
    valid_d = 1'b0;
    rsp_d   = rsp_q;
    we      = 1'b0;
    waddr   = slot_of(front_q, count_q);
    wdata   = req_i.value[DATA_WIDTH-1:0];
    raddr   = front_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = req_i.command;
          rsp_d.value_out = '0;
          rsp_d.status    = ST_OK;
          rsp_d.count     = count_q;
          case (req_i.command)
            CMD_ENQ: begin
              valid_d = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                rsp_d.status = ST_FULL;
              end else begin
                we            = 1'b1;
                count_d       = count_q + 1'b1;
                rsp_d.count   = count_q + 1'b1;
              end
            end
            CMD_DEQ: begin
              if (count_q == '0) begin
                valid_d      = 1'b1;
                rsp_d.status = ST_INVALID;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              raddr = slot_of(front_q, pos_ext);
              idx_d = req_i.position[ADDR_W-1:0];
              if (pos_ext >= count_q) begin
                valid_d      = 1'b1;
                rsp_d.status = ST_INVALID;
              end else if (req_i.command == CMD_REM) begin
                state_d = S_RMHD;
              end else begin
                state_d = S_READ;
              end
            end
          endcase
        end
      end
      S_READ: begin
        valid_d         = 1'b1;
        rsp_d.value_out = 32'(rdata);
        rsp_d.status    = ST_OK;
        rsp_d.count     = count_q;
        if (cmd_q == CMD_DEQ) begin
          front_d     = slot_of(front_q, CNT_W'(1));
          count_d     = count_q - 1'b1;
          rsp_d.count = count_q - 1'b1;
        end
        state_d = S_IDLE;
      end
      S_RMHD: begin
        valid_d         = 1'b1;
        rsp_d.value_out = 32'(rdata);
        rsp_d.status    = ST_OK;
        rsp_d.count     = count_q - 1'b1;
        count_d         = count_q - 1'b1;
        raddr           = slot_of(front_q, idx_ext + 1'b1);
        if (idx_ext + 1'b1 < count_q) begin
          state_d = S_SHIFT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = slot_of(front_q, idx_ext);
        wdata = rdata;
        idx_d = idx_q + 1'b1;
        raddr = slot_of(front_q, idx_ext + 2'd2);
        if (idx_ext + 1'b1 < count_q) begin
          state_d = S_SHIFT;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cmd_q <= cmd_d;
    rsp_q <= rsp_d;
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH))
  `ASSERT_IMPLY(a_full_only_when_full, valid_o && rsp_o.status == ST_FULL,
                rsp_o.count == CNT_W'(DEPTH))
  `ASSERT_IMPLY(a_reject_zero, valid_o && rsp_o.status != ST_OK, rsp_o.value_out == '0)
  `ASSERT_IMPLY(a_shift_no_overlap, state_q == S_SHIFT, waddr != raddr)

endmodule

`default_nettype wire
